// File: rtl/mslf_pkg.sv
package mslf_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int LENGTH_BITS   = 18;
    localparam int DIGIT_BITS    = 6;
    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_AW       = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int RESQ_DEPTH    = 2;
    localparam int RESQ_AW       = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_LF    = 8'h0a;
    localparam logic [7:0] CHR_CR    = 8'h0d;
    localparam logic [5:0] DIGIT_MASK = 6'h3f;

    typedef enum logic [1:0] {
        OP_START_WR = 2'd0,
        OP_WR_DATA  = 2'd1,
        OP_START_RD = 2'd2,
        OP_RX_BYTE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_RDATA = 2'd1,
        KIND_WACK  = 2'd2,
        KIND_RHDR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_CH_MISMATCH = 2'd1,
        ST_LEN_FAULT   = 2'd2
    } t_status;

    // One command from the front: either a four-byte header or a single
    // result, optionally followed by a carriage return.
    typedef struct packed {
        logic                   hdr;
        logic                   cr;
        t_kind                  kind;
        logic [7:0]             data;
        logic [7:0]             ack_ch;
        logic [LENGTH_BITS-1:0] ack_len;
        t_status                status;
        logic                   rts;
    } t_cmd;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             data;
        logic [7:0]             ack_ch;
        logic [LENGTH_BITS-1:0] ack_len;
        t_status                status;
        logic                   rts;
        logic                   last;
    } t_res;

endpackage

// File: rtl/mslf_front.sv
module mslf_front import mslf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [1:0]             i_op,
    input  logic [3:0]             i_channel,
    input  logic [LENGTH_BITS-1:0] i_length,
    input  logic [7:0]             i_data_byte,
    output logic                   o_cmd_push,
    output t_cmd                   o_cmd
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_WDATA    = 3'd1,
        PH_WACK_CH  = 3'd2,
        PH_WACK_LEN = 3'd3,
        PH_RHDR_CH  = 3'd4,
        PH_RHDR_LEN = 3'd5,
        PH_RDATA    = 3'd6
    } t_phase;

    t_phase                 r_phase,     n_phase;
    logic [3:0]             r_cur_ch,    n_cur_ch;
    logic [LENGTH_BITS-1:0] r_req_len,   n_req_len;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining;
    logic [1:0]             r_digit,     n_digit;
    logic [LENGTH_BITS-1:0] r_acc,       n_acc;
    logic [7:0]             r_reply_ch,  n_reply_ch;
    logic                   r_mismatch,  n_mismatch;
    logic                   r_rts,       n_rts;

    t_op                    op;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [LENGTH_BITS-1:0] acc_new;
    logic [1:0]             digit_inc;
    logic                   digit_done;
    logic [5:0]             digit_val;
    logic                   ch_ok;
    t_cmd                   cmd;
    logic                   cmd_push;

    assign op         = t_op'(i_op);
    assign rem_dec    = r_remaining - LENGTH_BITS'(1);
    assign digit_val  = 6'(i_data_byte - CHR_SPACE) & DIGIT_MASK;
    assign acc_new    = LENGTH_BITS'({r_acc, digit_val});
    assign digit_inc  = r_digit + 2'd1;
    assign digit_done = (digit_inc == 2'd3);
    assign ch_ok      = (int'(i_channel) < CHANNEL_COUNT);

    always_comb begin
        n_phase     = r_phase;
        n_cur_ch    = r_cur_ch;
        n_req_len   = r_req_len;
        n_remaining = r_remaining;
        n_digit     = r_digit;
        n_acc       = r_acc;
        n_reply_ch  = r_reply_ch;
        n_mismatch  = r_mismatch;
        n_rts       = r_rts;
        cmd_push    = 1'b0;
        cmd         = '0;
        cmd.kind    = KIND_LINE;
        cmd.status  = ST_OK;

        if (i_valid) begin
            unique case (op)
                OP_START_WR, OP_START_RD: begin
                    if (r_phase == PH_IDLE && ch_ok) begin
                        n_cur_ch    = i_channel;
                        n_req_len   = i_length;
                        n_digit     = 2'd0;
                        n_acc       = '0;
                        cmd_push    = 1'b1;
                        cmd.hdr     = 1'b1;
                        cmd.ack_len = i_length;
                        if (op == OP_START_WR) begin
                            n_remaining = i_length;
                            n_phase     = (i_length == '0) ? PH_WACK_CH : PH_WDATA;
                            cmd.data    = CHR_ZERO + {4'd0, i_channel};
                            cmd.rts     = r_rts;
                        end else begin
                            n_remaining = '0;
                            n_phase     = PH_RHDR_CH;
                            n_rts       = 1'b1;
                            cmd.data    = CHR_A + {4'd0, i_channel};
                            cmd.rts     = 1'b1;
                        end
                    end
                end
                OP_WR_DATA: begin
                    if (r_phase == PH_WDATA) begin
                        n_remaining = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = PH_WACK_CH;
                            n_digit = 2'd0;
                            n_acc   = '0;
                        end
                        cmd_push = 1'b1;
                        cmd.data = i_data_byte;
                        cmd.cr   = (i_data_byte == CHR_LF);
                        cmd.rts  = r_rts;
                    end
                end
                OP_RX_BYTE: begin
                    unique case (r_phase)
                        PH_WACK_CH, PH_RHDR_CH: begin
                            n_reply_ch = i_data_byte -
                                ((r_phase == PH_WACK_CH) ? CHR_A : CHR_ZERO);
                            n_mismatch = (n_reply_ch != {4'd0, r_cur_ch});
                            n_digit    = 2'd0;
                            n_acc      = '0;
                            n_phase    = (r_phase == PH_WACK_CH) ? PH_WACK_LEN
                                                                  : PH_RHDR_LEN;
                        end
                        PH_WACK_LEN: begin
                            n_acc   = acc_new;
                            n_digit = digit_done ? 2'd0 : digit_inc;
                            if (digit_done) begin
                                n_phase     = PH_IDLE;
                                cmd_push    = 1'b1;
                                cmd.kind    = KIND_WACK;
                                cmd.ack_ch  = r_reply_ch;
                                cmd.ack_len = acc_new;
                                cmd.rts     = r_rts;
                                if (r_mismatch) begin
                                    cmd.status = ST_CH_MISMATCH;
                                end else if (acc_new != r_req_len) begin
                                    cmd.status = ST_LEN_FAULT;
                                end
                            end
                        end
                        PH_RHDR_LEN: begin
                            n_acc   = acc_new;
                            n_digit = digit_done ? 2'd0 : digit_inc;
                            if (digit_done) begin
                                n_remaining = acc_new;
                                // zero-length reply ends the read here
                                if (acc_new == '0) begin
                                    n_rts   = 1'b0;
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_phase = PH_RDATA;
                                end
                                cmd_push    = 1'b1;
                                cmd.kind    = KIND_RHDR;
                                cmd.ack_ch  = r_reply_ch;
                                cmd.ack_len = acc_new;
                                cmd.rts     = n_rts;
                                if (r_mismatch) begin
                                    cmd.status = ST_CH_MISMATCH;
                                end else if (acc_new > r_req_len) begin
                                    cmd.status = ST_LEN_FAULT;
                                end
                            end
                        end
                        PH_RDATA: begin
                            n_remaining = rem_dec;
                            if (rem_dec == '0) begin
                                n_rts   = 1'b0;
                                n_phase = PH_IDLE;
                            end
                            cmd_push = 1'b1;
                            cmd.kind = KIND_RDATA;
                            cmd.data = i_data_byte;
                            cmd.rts  = n_rts;
                        end
                        default: begin
                            // drop: not expecting line bytes here
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cur_ch    <= '0;
            r_req_len   <= '0;
            r_remaining <= '0;
            r_digit     <= '0;
            r_acc       <= '0;
            r_reply_ch  <= '0;
            r_mismatch  <= 1'b0;
            r_rts       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cur_ch    <= n_cur_ch;
            r_req_len   <= n_req_len;
            r_remaining <= n_remaining;
            r_digit     <= n_digit;
            r_acc       <= n_acc;
            r_reply_ch  <= n_reply_ch;
            r_mismatch  <= n_mismatch;
            r_rts       <= n_rts;
        end
    end

    assign o_cmd_push = cmd_push;
    assign o_cmd      = cmd;

endmodule

// File: rtl/mslf_cmd_queue.sv
module mslf_cmd_queue import mslf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMDQ_AW:0]   r_count,  n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/mslf_back.sv
module mslf_back import mslf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);

    logic [1:0]         r_step, n_step;
    t_res               r_mem [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [RESQ_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [RESQ_AW:0]   r_count,  n_count;

    logic               res_full;
    logic               fire;
    logic               step_last;
    logic               do_pop;
    logic [1:0]         final_step;
    logic [5:0]         digit;
    t_res               res;

    assign res_full   = (r_count == (RESQ_AW+1)'(RESQ_DEPTH));
    assign fire       = i_cmd_valid && !res_full;
    assign final_step = i_cmd.hdr ? 2'd3 : (i_cmd.cr ? 2'd1 : 2'd0);
    assign step_last  = (r_step == final_step);
    assign do_pop     = i_pop && !o_empty;

    // header length digits, high digit first
    always_comb begin
        unique case (r_step)
            2'd1:    digit = 6'(i_cmd.ack_len >> (2 * DIGIT_BITS));
            2'd2:    digit = 6'(i_cmd.ack_len >> DIGIT_BITS);
            default: digit = 6'(i_cmd.ack_len);
        endcase
    end

    always_comb begin
        res      = '0;
        res.last = step_last;
        if (i_cmd.hdr) begin
            res.kind = KIND_LINE;
            res.data = (r_step == 2'd0) ? i_cmd.data : CHR_SPACE + {2'd0, digit};
            res.rts  = step_last ? i_cmd.rts : 1'b0;
        end else if (r_step != 2'd0) begin
            res.kind = KIND_LINE;
            res.data = CHR_CR;
            res.rts  = i_cmd.rts;
        end else begin
            res.kind    = i_cmd.kind;
            res.data    = i_cmd.data;
            res.ack_ch  = i_cmd.ack_ch;
            res.ack_len = i_cmd.ack_len;
            res.status  = i_cmd.status;
            res.rts     = i_cmd.rts;
        end
    end

    always_comb begin
        n_step   = r_step;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (fire) begin
            n_step   = step_last ? 2'd0 : r_step + 2'd1;
            n_wr_ptr = (r_wr_ptr == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + (RESQ_AW+1)'(fire) - (RESQ_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_mem[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_step   <= n_step;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_cmd_pop = fire && step_last;
    assign o_empty   = (r_count == '0);
    assign o_res     = r_mem[r_rd_ptr];

endmodule

// File: rtl/multiplexed_serial_link_framer.sv
// Serial link framer for channel-multiplexed transfers. Items enter through
// push/full and take effect in the cycle they are accepted; an item that its
// phase does not expect is dropped without results. Results leave through
// empty/pop, one per cycle at most: a start request yields four line bytes, a
// payload newline yields the byte and a carriage return, and every other item
// yields at most one result. A new item is taken every cycle while the
// two-entry command queue between the front parser and the result sequencer
// has room, so the sustained rate is set by the sequencer at one result per
// clock while its result queue has room. No clearing pass after reset.
module multiplexed_serial_link_framer import mslf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_op,
    input  logic [3:0]             i_channel,
    input  logic [LENGTH_BITS-1:0] i_length,
    input  logic [7:0]             i_data_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_out_byte,
    output logic [7:0]             o_ack_channel,
    output logic [LENGTH_BITS-1:0] o_ack_length,
    output logic [1:0]             o_status,
    output logic                   o_rts,
    output logic                   o_last
);

    logic accept;
    logic front_push;
    t_cmd front_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    t_res res;

    assign accept = push && !full;

    mslf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_op        (i_op),
        .i_channel   (i_channel),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .o_cmd_push  (front_push),
        .o_cmd       (front_cmd)
    );

    mslf_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    mslf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .o_res       (res),
        .i_pop       (pop)
    );

    assign o_kind        = res.kind;
    assign o_out_byte    = res.data;
    assign o_ack_channel = res.ack_ch;
    assign o_ack_length  = res.ack_len;
    assign o_status      = res.status;
    assign o_rts         = res.rts;
    assign o_last        = res.last;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import mslf_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 145;
    localparam int CALM_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [2:0] {
        LINK_IDLE,
        LINK_WR_DATA,
        LINK_WR_ACK_CH,
        LINK_WR_ACK_LEN,
        LINK_RD_HDR_CH,
        LINK_RD_HDR_LEN,
        LINK_RD_DATA
    } t_link_phase;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   push;
    logic                   full;
    logic [1:0]             i_op;
    logic [3:0]             i_channel;
    logic [LENGTH_BITS-1:0] i_length;
    logic [7:0]             i_data_byte;
    logic                   empty;
    logic                   pop;
    logic [1:0]             o_kind;
    logic [7:0]             o_out_byte;
    logic [7:0]             o_ack_channel;
    logic [LENGTH_BITS-1:0] o_ack_length;
    logic [1:0]             o_status;
    logic                   o_rts;
    logic                   o_last;

    // Predicted link state
    t_link_phase            link_phase;
    logic [3:0]             cur_ch;
    logic [LENGTH_BITS-1:0] req_len;
    logic [LENGTH_BITS-1:0] bytes_left;
    logic [1:0]             digit_cnt;
    logic [LENGTH_BITS-1:0] len_acc;
    logic [7:0]             reply_ch;
    logic                   ch_bad;
    logic                   rts_level;

    t_res framer_results[$];

    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned rx_stall_left;
    int unsigned quiet_cycles;
    int unsigned mismatches;
    int unsigned items_taken;
    int unsigned results_checked;
    int unsigned writes_run;
    int unsigned reads_run;

    multiplexed_serial_link_framer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_channel     (i_channel),
        .i_length      (i_length),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_ack_channel (o_ack_channel),
        .o_ack_length  (o_ack_length),
        .o_status      (o_status),
        .o_rts         (o_rts),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic void queue_result(input t_kind kind, input logic [7:0] data,
                                         input logic [7:0] ach,
                                         input logic [LENGTH_BITS-1:0] alen,
                                         input t_status st, input logic last);
        t_res r;
        r.kind    = kind;
        r.data    = data;
        r.ack_ch  = ach;
        r.ack_len = alen;
        r.status  = st;
        r.rts     = rts_level;
        r.last    = last;
        framer_results.push_back(r);
    endfunction

    function automatic logic take_digit(input logic [7:0] b);
        logic [7:0] d;
        d = (b - CHR_SPACE) & {2'b00, DIGIT_MASK};
        len_acc = (len_acc << DIGIT_BITS) | d[5:0];
        digit_cnt = digit_cnt + 2'd1;
        if (digit_cnt >= 2'd3) begin
            digit_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the link state for one accepted item and queue its results.
    // Return 0 when the item is dropped.
    function automatic bit frame_and_parse(input t_op op, input logic [3:0] ch,
                                           input logic [LENGTH_BITS-1:0] len,
                                           input logic [7:0] b);
        logic [7:0] head;
        t_status    st;
        case (op)
            OP_START_WR, OP_START_RD: begin
                if (link_phase != LINK_IDLE || ch >= CHANNEL_COUNT)
                    return 1'b0;
                cur_ch    = ch;
                req_len   = len;
                digit_cnt = '0;
                len_acc   = '0;
                if (op == OP_START_WR) begin
                    bytes_left = len;
                    link_phase = (len == '0) ? LINK_WR_ACK_CH : LINK_WR_DATA;
                    head = CHR_ZERO + {4'h0, ch};
                end else begin
                    bytes_left = '0;
                    link_phase = LINK_RD_HDR_CH;
                    head = CHR_A + {4'h0, ch};
                end
                queue_result(KIND_LINE, head, '0, '0, ST_OK, 1'b0);
                queue_result(KIND_LINE, CHR_SPACE + {2'b00, 6'(len >> (2 * DIGIT_BITS))},
                             '0, '0, ST_OK, 1'b0);
                queue_result(KIND_LINE, CHR_SPACE + {2'b00, 6'(len >> DIGIT_BITS)},
                             '0, '0, ST_OK, 1'b0);
                if (op == OP_START_RD)
                    rts_level = 1'b1;
                queue_result(KIND_LINE, CHR_SPACE + {2'b00, 6'(len)}, '0, '0, ST_OK, 1'b1);
                return 1'b1;
            end
            OP_WR_DATA: begin
                if (link_phase != LINK_WR_DATA)
                    return 1'b0;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    link_phase = LINK_WR_ACK_CH;
                    digit_cnt  = '0;
                    len_acc    = '0;
                end
                if (b == CHR_LF) begin
                    queue_result(KIND_LINE, b, '0, '0, ST_OK, 1'b0);
                    queue_result(KIND_LINE, CHR_CR, '0, '0, ST_OK, 1'b1);
                end else begin
                    queue_result(KIND_LINE, b, '0, '0, ST_OK, 1'b1);
                end
                return 1'b1;
            end
            default: begin
                case (link_phase)
                    LINK_WR_ACK_CH, LINK_RD_HDR_CH: begin
                        reply_ch  = b - ((link_phase == LINK_WR_ACK_CH) ? CHR_A : CHR_ZERO);
                        ch_bad    = (reply_ch != {4'h0, cur_ch});
                        digit_cnt = '0;
                        len_acc   = '0;
                        link_phase = (link_phase == LINK_WR_ACK_CH) ? LINK_WR_ACK_LEN
                                                                     : LINK_RD_HDR_LEN;
                        return 1'b1;
                    end
                    LINK_WR_ACK_LEN: begin
                        if (take_digit(b)) begin
                            st = ch_bad ? ST_CH_MISMATCH
                               : ((len_acc != req_len) ? ST_LEN_FAULT : ST_OK);
                            link_phase = LINK_IDLE;
                            queue_result(KIND_WACK, '0, reply_ch, len_acc, st, 1'b1);
                        end
                        return 1'b1;
                    end
                    LINK_RD_HDR_LEN: begin
                        if (take_digit(b)) begin
                            st = ch_bad ? ST_CH_MISMATCH
                               : ((len_acc > req_len) ? ST_LEN_FAULT : ST_OK);
                            bytes_left = len_acc;
                            if (bytes_left == '0) begin
                                rts_level  = 1'b0;
                                link_phase = LINK_IDLE;
                            end else begin
                                link_phase = LINK_RD_DATA;
                            end
                            queue_result(KIND_RHDR, '0, reply_ch, len_acc, st, 1'b1);
                        end
                        return 1'b1;
                    end
                    LINK_RD_DATA: begin
                        bytes_left = bytes_left - 1'b1;
                        if (bytes_left == '0) begin
                            rts_level  = 1'b0;
                            link_phase = LINK_IDLE;
                        end
                        queue_result(KIND_RDATA, b, '0, '0, ST_OK, 1'b1);
                        return 1'b1;
                    end
                    default: return 1'b0;
                endcase
            end
        endcase
    endfunction

    task automatic send_item(input t_op op, input logic [3:0] ch,
                             input logic [LENGTH_BITS-1:0] len, input logic [7:0] b);
        int unsigned gap;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push        <= 1'b1;
        i_op        <= op;
        i_channel   <= ch;
        i_length    <= len;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (frame_and_parse(op, ch, len, b))
            items_taken++;
    endtask

    // Set the two bits above the digit at random; the block masks them off.
    function automatic logic [7:0] digit_byte(input logic [5:0] d);
        return 8'(CHR_SPACE + d + ($urandom_range(0, 3) << 6));
    endfunction

    task automatic send_length(input logic [LENGTH_BITS-1:0] len);
        send_item(OP_RX_BYTE, 4'($urandom), 18'($urandom),
                  digit_byte(6'(len >> (2 * DIGIT_BITS))));
        send_item(OP_RX_BYTE, 4'($urandom), 18'($urandom), digit_byte(6'(len >> DIGIT_BITS)));
        send_item(OP_RX_BYTE, 4'($urandom), 18'($urandom), digit_byte(6'(len)));
    endtask

    // An item the current phase does not take: a start while busy, or a byte
    // meant for the other direction.
    task automatic send_stray(input bit in_write);
        t_op         op;
        int unsigned pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            op = OP_START_WR;
        else if (pick == 1)
            op = OP_START_RD;
        else
            op = in_write ? OP_RX_BYTE : OP_WR_DATA;
        send_item(op, 4'($urandom), 18'($urandom), 8'($urandom));
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic test_write_empty();
        send_item(OP_START_WR, 4'd0, '0, 8'h00);
        send_item(OP_RX_BYTE, 4'd0, '0, CHR_A);
        repeat (3) send_item(OP_RX_BYTE, 4'd0, '0, CHR_SPACE);
    endtask

    // Newline in the payload, then an ack with both the channel and the length wrong.
    task automatic test_write_newline_mismatch();
        send_item(OP_START_WR, 4'd15, 18'd2, 8'hff);
        send_item(OP_WR_DATA, 4'd15, '1, CHR_LF);
        send_item(OP_WR_DATA, 4'd0, '1, 8'hff);
        send_item(OP_RX_BYTE, 4'd0, '0, CHR_A + 8'd3);
        send_length(18'd5);
    endtask

    task automatic test_dropped_items();
        send_item(OP_RX_BYTE, 4'd15, '1, 8'hff);
        send_item(OP_WR_DATA, 4'd15, '1, 8'h00);
        send_item(OP_START_RD, 4'd15, '1, 8'h00);
        send_item(OP_START_WR, 4'd0, '0, 8'h00);
        send_item(OP_WR_DATA, 4'd0, '0, 8'h55);
        send_item(OP_RX_BYTE, 4'd0, '0, CHR_ZERO + 8'd15);
        // zero-length reply with junk above each digit; drops RTS
        send_item(OP_RX_BYTE, 4'd0, '0, 8'ha0);
        send_item(OP_RX_BYTE, 4'd0, '0, 8'h60);
        send_item(OP_RX_BYTE, 4'd0, '0, 8'he0);
    endtask

    task automatic test_read_excess();
        send_item(OP_START_RD, 4'd0, 18'd1, 8'hff);
        send_item(OP_RX_BYTE, 4'd0, '0, CHR_ZERO);
        send_length(18'd2);
        send_item(OP_RX_BYTE, 4'd0, '0, CHR_LF);
        send_item(OP_RX_BYTE, 4'd0, '0, 8'h00);
    endtask

    task automatic run_write();
        logic [3:0]             ch;
        logic [LENGTH_BITS-1:0] len;
        logic [7:0]             b;
        int unsigned            i;
        ch  = 4'($urandom);
        len = 18'($urandom_range(0, 6));
        send_item(OP_START_WR, ch, len, 8'($urandom));
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_stray(1'b1);
            b = ($urandom_range(0, 3) == 0) ? CHR_LF : 8'($urandom);
            send_item(OP_WR_DATA, 4'($urandom), 18'($urandom), b);
        end
        // garble the acknowledgement now and then
        send_item(OP_RX_BYTE, 4'($urandom), 18'($urandom),
                  ($urandom_range(0, 5) == 0) ? 8'($urandom) : CHR_A + {4'h0, ch});
        send_length(($urandom_range(0, 5) == 0) ? 18'($urandom) : len);
        writes_run++;
    endtask

    task automatic run_read();
        logic [3:0]             ch;
        logic [LENGTH_BITS-1:0] req;
        logic [LENGTH_BITS-1:0] reply;
        int unsigned            i;
        ch  = 4'($urandom);
        req = ($urandom_range(0, 1) != 0) ? 18'($urandom_range(0, 8)) : 18'($urandom);
        send_item(OP_START_RD, ch, req, 8'($urandom));
        if ($urandom_range(0, 5) == 0)
            send_stray(1'b0);
        send_item(OP_RX_BYTE, 4'($urandom), 18'($urandom),
                  ($urandom_range(0, 5) == 0) ? 8'($urandom) : CHR_ZERO + {4'h0, ch});
        reply = 18'($urandom_range(0, 8));
        send_length(reply);
        for (i = 0; i < reply; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_stray(1'b0);
            send_item(OP_RX_BYTE, 4'($urandom), 18'($urandom), 8'($urandom));
        end
        reads_run++;
    endtask

    task automatic test_random_transfers();
        int unsigned first;
        first = items_taken;
        while (items_taken - first < RANDOM_ITEMS) begin
            if (items_taken - first >= RANDOM_ITEMS - CALM_ITEMS) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            case ($urandom_range(0, 9))
                0: send_item(($urandom_range(0, 1) != 0) ? OP_WR_DATA : OP_RX_BYTE,
                             4'($urandom), 18'($urandom), 8'($urandom));
                1, 2, 3, 4: run_write();
                default: run_read();
            endcase
        end
    endtask

    // Result side: stall in random bursts while idling is on.
    always @(negedge i_clk) begin
        if (rx_stall_left != 0) begin
            rx_stall_left = rx_stall_left - 1;
            pop <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(0, 8);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (framer_results.size() == 0) begin
                $error("unexpected result transfer: kind %0h, byte %0h", o_kind, o_out_byte);
                mismatches++;
            end else begin
                want = framer_results.pop_front();
                compare_field("kind", want.kind, o_kind);
                compare_field("out_byte", want.data, o_out_byte);
                compare_field("ack_channel", want.ack_ch, o_ack_channel);
                compare_field("ack_length", want.ack_len, o_ack_length);
                compare_field("status", want.status, o_status);
                compare_field("rts", want.rts, o_rts);
                compare_field("last", want.last, o_last);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_op        = OP_START_WR;
        i_channel   = '0;
        i_length    = '0;
        i_data_byte = '0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        link_phase  = LINK_IDLE;
        cur_ch      = '0;
        req_len     = '0;
        bytes_left  = '0;
        digit_cnt   = '0;
        len_acc     = '0;
        reply_ch    = '0;
        ch_bad      = 1'b0;
        rts_level   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_write_empty();
        test_write_newline_mismatch();
        test_dropped_items();
        test_read_excess();
        test_random_transfers();

        @(negedge i_clk);
        push <= 1'b0;
        while (framer_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Directed framing cases plus %0d random writes and %0d random reads,",
                 writes_run, reads_run);
        $display("%0d items taken, %0d results checked, %0d mismatches.",
                 items_taken, results_checked, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
